/* src/palette_led_matrix_editor_macros.svh */
// Assertion macros for the palette LED matrix editor.
// Included by the RTL files that carry concurrent assertions; no dependencies.
`ifndef PALETTE_LED_MATRIX_EDITOR_MACROS_SVH
`define PALETTE_LED_MATRIX_EDITOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define PLME_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLME_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PLME_ASSERT_RST(lbl, clk, rst, prop, msg)
`define PLME_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/plme_pkg.sv */
// Package for the palette LED matrix editor: state and action types, constants,
// palette ROM and blink test. No dependencies.
package plme_pkg;

  localparam int CHAN_W = 8;
  localparam int GAIN_W = 16;
  localparam int BTN_W  = 4;
  localparam int IDX_W  = 4;
  localparam int RGB_W  = 3 * CHAN_W;
  localparam int TICK_W = 8;

  localparam logic [GAIN_W-1:0] GAIN_RESET   = 16'd3277;
  localparam int                BLINK_PERIOD = 42;

  localparam int BTN_FRAME  = 0;
  localparam int BTN_COLOUR = 1;
  localparam int BTN_ROW    = 2;
  localparam int BTN_COL    = 3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW_RD,
    S_RMW_WR,
    S_PIX_RD,
    S_PIX_LOAD,
    S_MUL,
    S_OUT
  } plme_state_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_COL,
    ACT_ROW,
    ACT_COLOUR,
    ACT_FRAME
  } plme_act_t;

  function automatic logic [RGB_W-1:0] palette_rgb(input logic [IDX_W-1:0] idx);
    logic [RGB_W-1:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hf44336;
      4'd2:    rgb = 24'he81e63;
      4'd3:    rgb = 24'h9c27b0;
      4'd4:    rgb = 24'h673ab7;
      4'd5:    rgb = 24'h3f51b5;
      4'd6:    rgb = 24'h2196f3;
      4'd7:    rgb = 24'h00bcd4;
      4'd8:    rgb = 24'h009688;
      4'd9:    rgb = 24'h4caf50;
      4'd10:   rgb = 24'h8bc34a;
      4'd11:   rgb = 24'hcddc39;
      4'd12:   rgb = 24'hffeb3b;
      4'd13:   rgb = 24'hffc107;
      4'd14:   rgb = 24'hff9800;
      default: rgb = 24'hffffff;
    endcase
    return rgb;
  endfunction

  function automatic logic blink_tick(input logic [TICK_W-1:0] t);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= 255 / BLINK_PERIOD; k++) begin
      if (t == TICK_W'(k * BLINK_PERIOD)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

/* src/palette_led_matrix_editor.sv */
// Top level of the palette LED matrix editor: sequencer, button latch, cursor and
// frame state. Depends on plme_pkg, plme_ram, plme_scale and the macro header.
//
//   channel | dir | handshake          | fields
//   in      | in  | in_valid/in_stall  | in_buttons
//   out     | out | out_valid/out_stall| out_pixel_index, out_green, out_red,
//           |     |                    | out_blue, out_last
//   cfg     | in  | cfg_wr_en          | cfg_wr_data (brightness gain)
//
// After reset a clearing pass fills the pixel store. A tick that cycles a colour first reads
// and rewrites the pixel under the cursor; out_stall holds the pixel transfers.
// Per pixel: one pixel store read, three passes through the shared multiplier, one transfer.
// in_stall is high from an accepted tick until its last pixel transfer.
`include "palette_led_matrix_editor_macros.svh"

module palette_led_matrix_editor
  import plme_pkg::*;
#(
  parameter int FRAME_COUNT = 4,
  parameter int MATRIX_SIDE = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BTN_W-1:0]  in_buttons,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_pixel_index,
  output logic [CHAN_W-1:0] out_green,
  output logic [CHAN_W-1:0] out_red,
  output logic [CHAN_W-1:0] out_blue,
  output logic              out_last,
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data
);

  localparam int CW     = $clog2(MATRIX_SIDE);
  localparam int FW     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int AW     = FW + 2 * CW;
  localparam int PIXELS = MATRIX_SIDE * MATRIX_SIDE;
  localparam int PW     = $clog2(PIXELS);

  localparam logic [CW-1:0] SIDE_MAX  = CW'(MATRIX_SIDE - 1);
  localparam logic [FW-1:0] FRAME_MAX = FW'(FRAME_COUNT - 1);
  localparam logic [PW-1:0] PIX_MAX   = PW'(PIXELS - 1);

  plme_state_t       state_r, state_nxt;
  logic [GAIN_W-1:0] gain_r;
  logic [CW-1:0]     cur_col_r, cur_row_r;
  logic [FW-1:0]     frame_r;
  logic [TICK_W-1:0] tick_r;
  logic [BTN_W-1:0]  flags_r;
  logic              latched_r;
  logic [CW-1:0]     snap_col_r, snap_row_r;
  logic              invert_r;
  logic [AW-1:0]     clr_addr_r;
  logic [CW-1:0]     col_r, row_r;
  logic [PW-1:0]     pidx_r;
  logic [1:0]        mul_cnt_r;
  logic [RGB_W-1:0]  rgb_r;
  logic [5:0]        out_pixel_index_r;
  logic [CHAN_W-1:0] out_green_r, out_red_r, out_blue_r;
  logic              out_last_r;

  logic [BTN_W-1:0]  flags_v;
  logic              latched_v;
  plme_act_t         act;
  logic              in_xfer, out_xfer;
  logic [CW-1:0]     col_adv, row_adv;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [IDX_W-1:0]  ram_wdata, ram_rdata;

  logic              mul_en;
  logic [CHAN_W-1:0] mul_chan, mul_res;
  logic [RGB_W-1:0]  pix_rgb;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  always_comb begin
    flags_v   = flags_r;
    latched_v = latched_r;
    if (flags_v == '0) begin
      flags_v = in_buttons;
    end else if (latched_v && in_buttons == '0) begin
      flags_v   = '0;
      latched_v = 1'b0;
    end
    act = ACT_NONE;
    if (!latched_v) begin
      if (flags_v[BTN_COL]) begin
        act = ACT_COL;
      end else if (flags_v[BTN_ROW]) begin
        act = ACT_ROW;
      end else if (flags_v[BTN_COLOUR]) begin
        act = ACT_COLOUR;
      end else if (flags_v[BTN_FRAME]) begin
        act = ACT_FRAME;
      end
    end
  end

  always_comb begin
    col_adv = (col_r == SIDE_MAX) ? '0 : col_r + 1'b1;
    row_adv = row_r;
    if (col_r == SIDE_MAX) begin
      row_adv = (row_r == SIDE_MAX) ? '0 : row_r + 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (act == ACT_COLOUR) ? S_RMW_RD : S_PIX_RD;
        end
      end
      S_RMW_RD:   state_nxt = S_RMW_WR;
      S_RMW_WR:   state_nxt = S_PIX_RD;
      S_PIX_RD:   state_nxt = S_PIX_LOAD;
      S_PIX_LOAD: state_nxt = S_MUL;
      S_MUL: begin
        if (mul_cnt_r == 2'd3) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = out_last_r ? S_IDLE : S_PIX_LOAD;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = IDX_W'(clr_addr_r[AW-1 -: FW]);
    ram_re    = 1'b0;
    ram_raddr = {frame_r, row_r, col_r};
    mul_en    = 1'b0;
    mul_chan  = '0;
    unique case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_RMW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = {frame_r, snap_row_r, snap_col_r};
      end
      S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_waddr = {frame_r, snap_row_r, snap_col_r};
        ram_wdata = ram_rdata + 1'b1;
      end
      S_PIX_RD: begin
        ram_re = 1'b1;
      end
      S_PIX_LOAD: begin
      end
      S_MUL: begin
        mul_en = 1'b1;
        case (mul_cnt_r)
          2'd0:    mul_chan = rgb_r[15:8];
          2'd1:    mul_chan = rgb_r[23:16];
          2'd2:    mul_chan = rgb_r[7:0];
          default: mul_chan = '0;
        endcase
      end
      S_OUT: begin
        out_valid = 1'b1;
        ram_re    = !out_stall && !out_last_r;
        ram_raddr = {frame_r, row_adv, col_adv};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    pix_rgb = palette_rgb(ram_rdata);
    if (invert_r && col_r == snap_col_r && row_r == snap_row_r) begin
      pix_rgb = ~pix_rgb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      gain_r     <= GAIN_RESET;
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      frame_r    <= '0;
      tick_r     <= '0;
      flags_r    <= '0;
      latched_r  <= 1'b0;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pidx_r     <= '0;
      mul_cnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        gain_r <= cfg_wr_data;
      end
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (in_xfer) begin
        flags_r   <= flags_v;
        latched_r <= latched_v || (act != ACT_NONE);
        tick_r    <= tick_r + 1'b1;
        col_r     <= '0;
        row_r     <= '0;
        pidx_r    <= '0;
        if (act == ACT_COL) begin
          cur_col_r <= (cur_col_r == SIDE_MAX) ? '0 : cur_col_r + 1'b1;
        end
        if (act == ACT_ROW) begin
          cur_row_r <= (cur_row_r == SIDE_MAX) ? '0 : cur_row_r + 1'b1;
        end
        if (act == ACT_FRAME) begin
          frame_r <= (frame_r == FRAME_MAX) ? '0 : frame_r + 1'b1;
        end
      end
      if (state_r == S_PIX_LOAD) begin
        mul_cnt_r <= '0;
      end else if (state_r == S_MUL) begin
        mul_cnt_r <= mul_cnt_r + 1'b1;
      end
      if (state_r == S_OUT && out_xfer && !out_last_r) begin
        col_r  <= col_adv;
        row_r  <= row_adv;
        pidx_r <= pidx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      snap_col_r <= cur_col_r;
      snap_row_r <= cur_row_r;
      invert_r   <= blink_tick(tick_r + 1'b1);
    end
    if (state_r == S_PIX_LOAD) begin
      rgb_r             <= pix_rgb;
      out_pixel_index_r <= 6'(pidx_r);
      out_last_r        <= (pidx_r == PIX_MAX);
    end
    if (state_r == S_MUL) begin
      case (mul_cnt_r)
        2'd1:    out_green_r <= mul_res;
        2'd2:    out_red_r   <= mul_res;
        2'd3:    out_blue_r  <= mul_res;
        default: begin
        end
      endcase
    end
  end

  plme_ram #(
    .WIDTH(IDX_W),
    .DEPTH(1 << AW)
  ) u_pixel_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  plme_scale u_scale (
    .clk (clk),
    .en  (mul_en),
    .chan(mul_chan),
    .gain(gain_r),
    .res (mul_res)
  );

  assign out_pixel_index = out_pixel_index_r;
  assign out_green       = out_green_r;
  assign out_red         = out_red_r;
  assign out_blue        = out_blue_r;
  assign out_last        = out_last_r;

  `PLME_ASSERT_RST(a_tick_starts_work, clk, !rst_n, in_xfer |=> state_r != S_IDLE, "tick transfer did not start work")
  `PLME_ASSERT_RST(a_last_ends_tick, clk, !rst_n, (out_xfer && out_last) |=> state_r == S_IDLE, "last pixel did not end the tick")
  `PLME_ASSERT_RST(a_last_at_end, clk, !rst_n, (out_valid && out_last) |-> pidx_r == PIX_MAX, "last flag away from final pixel")
  `PLME_ASSERT_RST(a_store_write_phase, clk, !rst_n, ram_we |-> (state_r == S_CLEAR || state_r == S_RMW_WR), "pixel store written outside clear or colour update")
  `PLME_ASSERT_ALWAYS(a_reset_clears, clk, !$past(rst_n) |-> state_r == S_CLEAR, "reset did not restart the clearing pass")

endmodule

/* src/plme_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module plme_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/plme_scale.sv */
// Shared channel scaler: one 8x16 multiplier, result registered and shifted by 16.
// Depends on plme_pkg.
module plme_scale
  import plme_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [CHAN_W-1:0] chan,
  input  logic [GAIN_W-1:0] gain,
  output logic [CHAN_W-1:0] res
);

  logic [CHAN_W+GAIN_W-1:0] prod;
  logic [CHAN_W-1:0]        res_r;

  assign prod = chan * gain;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= prod[CHAN_W+GAIN_W-1 -: CHAN_W];
    end
  end

  assign res = res_r;

endmodule
